// ----- rtl/core/udfold_pkg.sv -----
`timescale 1ns / 1ps

package udfold_pkg;

  // fold_mode codes; the unused code behaves as pass-through
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_TWO  = 2'd2;

  // depth of the queue between front and back, in entries
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // one accepted byte turns into up to three output bytes, slot 0 first
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] bytes;
    logic            last;
    logic            changed;
  } entry_t;

  typedef struct packed {
    logic       hit;
    logic       has_two;
    logic [7:0] one;
    logic [7:0] two0;
    logic [7:0] two1;
  } fold_hit_t;

  function automatic fold_hit_t fold_lookup(input logic [7:0] lead, input logic [7:0] trail);
    fold_hit_t r;
    r = '0;
    r.hit = 1'b1;
    case ({lead, trail})
      16'hC384: begin r.one = "A"; r.has_two = 1'b1; r.two0 = "A"; r.two1 = "E"; end
      16'hC396: begin r.one = "O"; r.has_two = 1'b1; r.two0 = "O"; r.two1 = "E"; end
      16'hC39C: begin r.one = "U"; r.has_two = 1'b1; r.two0 = "U"; r.two1 = "E"; end
      16'hC3A4: begin r.one = "a"; r.has_two = 1'b1; r.two0 = "a"; r.two1 = "e"; end
      16'hC3B6: begin r.one = "o"; r.has_two = 1'b1; r.two0 = "o"; r.two1 = "e"; end
      16'hC3BC: begin r.one = "u"; r.has_two = 1'b1; r.two0 = "u"; r.two1 = "e"; end
      16'hC39F: begin r.one = "s"; r.has_two = 1'b1; r.two0 = "s"; r.two1 = "s"; end
      16'hC590: r.one = "O";
      16'hC5B0: r.one = "U";
      16'hC381: r.one = "A";
      16'hC486: r.one = "C";
      16'hC389: r.one = "E";
      16'hC38D: r.one = "I";
      16'hC583: r.one = "N";
      16'hC393: r.one = "O";
      16'hC59A: r.one = "S";
      16'hC39A: r.one = "U";
      16'hC5B9: r.one = "Z";
      16'hC484: r.one = "A";
      16'hC498: r.one = "E";
      16'hC5BB: r.one = "Z";
      16'hC581: r.one = "L";
      16'hC591: r.one = "o";
      16'hC5B1: r.one = "u";
      16'hC3A1: r.one = "a";
      16'hC487: r.one = "c";
      16'hC3A9: r.one = "e";
      16'hC3AD: r.one = "i";
      16'hC584: r.one = "n";
      16'hC3B3: r.one = "o";
      16'hC59B: r.one = "s";
      16'hC3BA: r.one = "u";
      16'hC5BA: r.one = "z";
      16'hC485: r.one = "a";
      16'hC499: r.one = "e";
      16'hC5BC: r.one = "z";
      16'hC582: r.one = "l";
      default:  r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/udfold_front.sv -----
`timescale 1ns / 1ps

module udfold_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_data_i,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  input  logic                eos_i,
  output udfold_pkg::entry_t  entry_o,
  output logic                push_o
);

  logic [1:0] mode_q;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic [1:0] held_cnt_q, held_cnt_d;
  logic       any_q, any_d;

  logic                  folding;
  logic                  cont;
  logic                  fresh_hold;
  logic [7:0]            pair_trail;
  udfold_pkg::fold_hit_t hit;
  logic [1:0]            pair_n;
  logic [7:0]            pair0, pair1;
  logic                  pair_rep;
  logic                  rep_new;
  udfold_pkg::entry_t    e;

  assign folding    = (mode_q == udfold_pkg::MODE_ONE) || (mode_q == udfold_pkg::MODE_TWO);
  assign cont       = (byte_i[7:6] == 2'b10);
  assign fresh_hold = !eos_i && (byte_i >= 8'hC3) && (byte_i <= 8'hC5);
  assign pair_trail = (held_cnt_q == 2'd1) ? byte_i : second_q;
  assign hit        = udfold_pkg::fold_lookup(first_q, pair_trail);

  always_comb begin
    pair_n   = 2'd2;
    pair0    = first_q;
    pair1    = pair_trail;
    pair_rep = 1'b0;
    if (hit.hit && mode_q == udfold_pkg::MODE_ONE) begin
      pair_n   = 2'd1;
      pair0    = hit.one;
      pair_rep = 1'b1;
    end else if (hit.hit && hit.has_two) begin
      pair0    = hit.two0;
      pair1    = hit.two1;
      pair_rep = 1'b1;
    end
  end

  always_comb begin
    e          = '0;
    held_cnt_d = 2'd0;
    first_d    = first_q;
    second_d   = second_q;
    rep_new    = any_q;
    if (!folding) begin
      case (held_cnt_q)
        2'd1: begin
          e.bytes[0] = first_q;
          e.bytes[1] = byte_i;
          e.n        = 2'd2;
        end
        2'd2: begin
          e.bytes = {byte_i, second_q, first_q};
          e.n     = 2'd3;
        end
        default: begin
          e.bytes[0] = byte_i;
          e.n        = 2'd1;
        end
      endcase
    end else begin
      case (held_cnt_q)
        2'd1: begin
          if (cont) begin
            if (eos_i) begin
              e.bytes[0] = pair0;
              e.bytes[1] = pair1;
              e.n        = pair_n;
              rep_new    = any_q | pair_rep;
            end else begin
              second_d   = byte_i;
              held_cnt_d = 2'd2;
            end
          end else begin
            e.bytes[0] = first_q;
            if (fresh_hold) begin
              first_d    = byte_i;
              held_cnt_d = 2'd1;
              e.n        = 2'd1;
            end else begin
              e.bytes[1] = byte_i;
              e.n        = 2'd2;
            end
          end
        end
        2'd2: begin
          if (cont) begin
            e.bytes = {byte_i, second_q, first_q};
            e.n     = 2'd3;
          end else begin
            // the held character ends here, fold it then look at this byte
            e.bytes[0] = pair0;
            e.bytes[1] = pair1;
            rep_new    = any_q | pair_rep;
            if (fresh_hold) begin
              first_d    = byte_i;
              held_cnt_d = 2'd1;
              e.n        = pair_n;
            end else if (pair_n == 2'd1) begin
              e.bytes[1] = byte_i;
              e.n        = 2'd2;
            end else begin
              e.bytes[2] = byte_i;
              e.n        = 2'd3;
            end
          end
        end
        default: begin
          if (fresh_hold) begin
            first_d    = byte_i;
            held_cnt_d = 2'd1;
          end else begin
            e.bytes[0] = byte_i;
            e.n        = 2'd1;
          end
        end
      endcase
    end
    e.last    = eos_i;
    e.changed = eos_i & (!folding | rep_new);
    any_d     = eos_i ? 1'b0 : rep_new;
  end

  assign entry_o = e;
  assign push_o  = accept_i && (e.n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= udfold_pkg::MODE_PASS;
      first_q    <= '0;
      second_q   <= '0;
      held_cnt_q <= '0;
      any_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (accept_i) begin
        first_q    <= first_d;
        second_q   <= second_d;
        held_cnt_q <= held_cnt_d;
        any_q      <= any_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_pass_holds_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !folding |=> held_cnt_q == 2'd0)
    else $error("bytes held in pass-through mode");

  a_eos_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && eos_i |=> held_cnt_q == 2'd0 && !any_q)
    else $error("state left over after end of string");

  a_eos_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && eos_i |-> push_o)
    else $error("end of string produced no byte");
`endif

endmodule

// ----- rtl/core/udfold_queue.sv -----
`timescale 1ns / 1ps

module udfold_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  udfold_pkg::entry_t entry_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output udfold_pkg::entry_t head_o
);

  udfold_pkg::entry_t mem_q [udfold_pkg::QDEPTH];

  logic [udfold_pkg::QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [udfold_pkg::QAW:0]   cnt_q;

  assign ready_o = (cnt_q != (udfold_pkg::QAW + 1)'(udfold_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/udfold_back.sv -----
`timescale 1ns / 1ps

module udfold_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  udfold_pkg::entry_t head_i,
  output logic               pop_o,
  output logic               tvalid_o,
  input  logic               tready_i,
  output logic [7:0]         tdata_o,
  output logic               tlast_o,
  output logic               tuser_o
);

  logic [1:0] idx_q, idx_d;
  logic       final_byte;
  logic       xfer;

  assign final_byte = (idx_q == head_i.n - 2'd1);
  assign xfer       = valid_i && tready_i;
  assign tvalid_o   = valid_i;
  assign tdata_o    = head_i.bytes[idx_q];
  // end-of-string marks go on the last byte of the final entry only
  assign tlast_o    = head_i.last & final_byte;
  assign tuser_o    = head_i.changed & final_byte;
  assign pop_o      = xfer && final_byte;

  always_comb begin
    idx_d = idx_q;
    if (xfer) begin
      idx_d = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_head_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> head_i.n != 2'd0 && idx_q < head_i.n)
    else $error("slot index outside queued entry");

  a_idle_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |-> idx_q == 2'd0)
    else $error("slot index not cleared between entries");
`endif

endmodule

// ----- rtl/core/utf8_diacritic_folder.sv -----
`timescale 1ns / 1ps

// utf8 diacritic folder
// s_axis carries one string byte per transfer, tlast on the final byte of a
// string. m_axis returns the folded string one byte per transfer, tlast on its
// final byte and tuser set there if anything was replaced (or in pass-through).
// cfg_valid_i/cfg_data_i write fold_mode (0 pass, 1 single letter, 2 expanded
// spelling); cfg_ready_o is always high. The user writes only while the block
// is idle; the block itself does not enforce this. The front end classifies
// each byte against up to two held bytes and pushes a group of 1 to 3 output
// bytes into a four-entry queue; the back end sends the group out one byte per
// cycle while m_axis_tready is high. A byte that is not held is written into
// the queue on its transfer and reaches m_axis once earlier entries are sent.
// A candidate lead byte and its continuation are held until the next byte or
// the end of the string shows where the character ends. Throughput: one input
// byte per cycle while every group is a single byte and m_axis_tready is high;
// bigger groups go out byte by byte; s_axis_tready drops once the queue is full.
// Reset clears the mode to pass-through, the held bytes and the queue.
// When m_axis_tready is low the output holds and the queue fills.
module utf8_diacritic_folder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // byte_in
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // byte_out
  output logic       m_axis_tlast,
  output logic [0:0] m_axis_tuser    // string_changed
);

  udfold_pkg::entry_t entry, head;
  logic               push, pop, q_ready, q_valid, accept;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = q_ready;
  assign accept        = s_axis_tvalid && q_ready;

  udfold_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .eos_i       (s_axis_tlast),
    .entry_o     (entry),
    .push_o      (push)
  );

  udfold_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  udfold_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .head_i   (head),
    .pop_o    (pop),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast),
    .tuser_o  (m_axis_tuser[0])
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  // the spare mode code, folded like pass-through
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // {lead, trail, single letter, expanded first, expanded second}
  localparam logic [39:0] FOLD_TAB [37] = '{
    40'hC384_41_41_45, 40'hC396_4F_4F_45, 40'hC39C_55_55_45, 40'hC590_4F_00_00,
    40'hC5B0_55_00_00, 40'hC381_41_00_00, 40'hC486_43_00_00, 40'hC389_45_00_00,
    40'hC38D_49_00_00, 40'hC583_4E_00_00, 40'hC393_4F_00_00, 40'hC59A_53_00_00,
    40'hC39A_55_00_00, 40'hC5B9_5A_00_00, 40'hC484_41_00_00, 40'hC498_45_00_00,
    40'hC5BB_5A_00_00, 40'hC581_4C_00_00, 40'hC3A4_61_61_65, 40'hC3B6_6F_6F_65,
    40'hC3BC_75_75_65, 40'hC591_6F_00_00, 40'hC5B1_75_00_00, 40'hC3A1_61_00_00,
    40'hC487_63_00_00, 40'hC3A9_65_00_00, 40'hC3AD_69_00_00, 40'hC584_6E_00_00,
    40'hC3B3_6F_00_00, 40'hC59B_73_00_00, 40'hC3BA_75_00_00, 40'hC5BA_7A_00_00,
    40'hC485_61_00_00, 40'hC499_65_00_00, 40'hC5BC_7A_00_00, 40'hC582_6C_00_00,
    40'hC39F_73_73_73
  };

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_e;
  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       changed;
  } folded_byte_t;

  class fold_scoreboard;
    folded_byte_t folded_q [$];
    logic [1:0]   cur_mode;
    logic [7:0]   lead_byte;
    logic [7:0]   cont_byte;
    logic [1:0]   n_held;
    logic         replaced_seen;
    int           grp_n;
    int           n_in;
    int           n_out;
    int           errors;

    function new();
      cur_mode      = udfold_pkg::MODE_PASS;
      lead_byte     = '0;
      cont_byte     = '0;
      n_held        = '0;
      replaced_seen = 1'b0;
      n_in          = 0;
      n_out         = 0;
      errors        = 0;
    endfunction

    function void set_mode(logic [1:0] m);
      cur_mode = m;
    endfunction

    function int pending();
      return folded_q.size();
    endfunction

    function void emit(logic [7:0] b);
      folded_byte_t e;
      e.data    = b;
      e.last    = 1'b0;
      e.changed = 1'b0;
      folded_q.push_back(e);
      grp_n++;
    endfunction

    function void fold_pair(logic [7:0] lead, logic [7:0] trail);
      logic       hit;
      logic [7:0] one;
      logic [7:0] two0;
      logic [7:0] two1;
      hit  = 1'b0;
      one  = '0;
      two0 = '0;
      two1 = '0;
      for (int i = 0; i < 37; i++) begin
        if (!hit && FOLD_TAB[i][39:24] == {lead, trail}) begin
          hit  = 1'b1;
          one  = FOLD_TAB[i][23:16];
          two0 = FOLD_TAB[i][15:8];
          two1 = FOLD_TAB[i][7:0];
        end
      end
      if (hit && cur_mode == udfold_pkg::MODE_ONE) begin
        replaced_seen = 1'b1;
        emit(one);
      end else if (hit && two0 != 8'h00) begin
        replaced_seen = 1'b1;
        emit(two0);
        emit(two1);
      end else begin
        emit(lead);
        emit(trail);
      end
    endfunction

    // candidate leads wait for the next byte unless the string ends here
    function void take_fresh(logic [7:0] b, logic eos);
      if (!eos && b >= 8'hC3 && b <= 8'hC5) begin
        lead_byte = b;
        n_held    = 2'd1;
      end else begin
        emit(b);
      end
    endfunction

    function void note_input(logic [7:0] b, logic eos);
      logic         folding;
      logic         is_cont;
      logic [1:0]   cnt;
      folded_byte_t tail;
      folding = (cur_mode == udfold_pkg::MODE_ONE) || (cur_mode == udfold_pkg::MODE_TWO);
      is_cont = (b[7:6] == 2'b10);
      cnt     = n_held;
      n_held  = 2'd0;
      grp_n   = 0;
      n_in++;
      if (!folding) begin
        if (cnt >= 2'd1) emit(lead_byte);
        if (cnt >= 2'd2) emit(cont_byte);
        emit(b);
      end else if (cnt == 2'd1) begin
        if (is_cont && eos) begin
          fold_pair(lead_byte, b);
        end else if (is_cont) begin
          cont_byte = b;
          n_held    = 2'd2;
        end else begin
          emit(lead_byte);
          take_fresh(b, eos);
        end
      end else if (cnt == 2'd2) begin
        if (is_cont) begin
          // three bytes or more: copied unchanged
          emit(lead_byte);
          emit(cont_byte);
          emit(b);
        end else begin
          fold_pair(lead_byte, cont_byte);
          take_fresh(b, eos);
        end
      end else begin
        take_fresh(b, eos);
      end
      if (eos) begin
        if (grp_n > 0) begin
          tail         = folded_q.pop_back();
          tail.last    = 1'b1;
          tail.changed = !folding || replaced_seen;
          folded_q.push_back(tail);
        end
        replaced_seen = 1'b0;
      end
    endfunction

    function void check_output(logic [7:0] data, logic last, logic changed);
      folded_byte_t e;
      n_out++;
      if (folded_q.size() == 0) begin
        $error("unexpected output transfer: byte_out %h", data);
        errors++;
      end else begin
        e = folded_q.pop_front();
        if (data !== e.data) begin
          $error("byte_out: expected %h, actual %h", e.data, data);
          errors++;
        end
        if (last !== e.last) begin
          $error("last_of_string: expected %b, actual %b", e.last, last);
          errors++;
        end
        if (changed !== e.changed) begin
          $error("string_changed: expected %b, actual %b", e.changed, changed);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i    = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // byte_in
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // byte_out
  logic       m_axis_tlast;
  logic [0:0] m_axis_tuser;         // string_changed

  idle_e          idle_mode = IDLE_NONE;
  fold_scoreboard sb;

  utf8_diacritic_folder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // output side: check each transfer, then choose the next stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
      end
      case (idle_mode)
        IDLE_SNK:  m_axis_tready <= ($urandom_range(99) >= 84);
        IDLE_BOTH: m_axis_tready <= ($urandom_range(99) >= 6);
        default:   m_axis_tready <= 1'b1;
      endcase
    end
  end

  // valid is left high after a transfer so back-to-back bytes need no toggle
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SRC) ? 84 : (idle_mode == IDLE_BOTH) ? 6 : 0;
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(b, eos);
  endtask

  task automatic send_seq(input byte_q_t s, input logic close);
    foreach (s[k]) send_byte(s[k], close && (k == s.size() - 1));
  endtask

  // bytes may still be held inside, so drain the expected output and let the block settle
  task automatic write_mode(input logic [1:0] m);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_mode(m);
  endtask

  // mostly well-formed characters with random content, some noise
  task automatic send_random(input int count);
    logic [7:0]  tok [4];
    logic [39:0] ent;
    int          nb;
    int          kind;
    int          sent;
    sent = 0;
    while (sent < count) begin
      kind   = $urandom_range(99);
      tok[1] = 8'h80 | 8'($urandom_range(63));
      tok[2] = 8'h80 | 8'($urandom_range(63));
      tok[3] = 8'h80 | 8'($urandom_range(63));
      if (kind < 35) begin
        ent    = FOLD_TAB[$urandom_range(36)];
        tok[0] = ent[39:32];
        tok[1] = ent[31:24];
        nb     = 2;
      end else if (kind < 55) begin
        tok[0] = 8'($urandom_range(8'h7E, 8'h20));
        nb     = 1;
      end else if (kind < 65) begin
        tok[0] = 8'($urandom_range(8'hC5, 8'hC3));
        nb     = 2;
      end else if (kind < 70) begin
        tok[0] = 8'($urandom_range(8'hEF, 8'hE0));
        nb     = 3;
      end else if (kind < 75) begin
        tok[0] = 8'($urandom_range(8'hC5, 8'hC3));
        nb     = 3;
      end else if (kind < 80) begin
        tok[0] = 8'($urandom_range(8'hF4, 8'hF0));
        nb     = 4;
      end else if (kind < 90) begin
        tok[0] = 8'($urandom_range(255));
        nb     = 1;
      end else begin
        tok[0] = 8'($urandom_range(8'hC5, 8'hC3));
        nb     = 1;
      end
      for (int k = 0; k < nb; k++) begin
        send_byte(tok[k], ($urandom_range(9) == 0));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic [1:0] m, input idle_e profile, input int count);
    write_mode(m);
    idle_mode = profile;
    send_random(count);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset mode passes an accented letter through
    send_seq('{8'hC3, 8'h84}, 1'b1);

    write_mode(udfold_pkg::MODE_ONE);
    send_seq('{8'hC3, 8'h84, 8'h61}, 1'b1);
    // string ends right on the continuation byte
    send_seq('{8'hC5, 8'hBC}, 1'b1);
    // stray continuation, longer character, lead without continuation,
    // nul and all-ones bytes, candidate lead as the final byte
    send_seq('{8'h80, 8'hC3, 8'hA4, 8'h80, 8'hC4, 8'h41, 8'h00, 8'hFF, 8'hC3}, 1'b1);
    // lead held while the mode drops to pass-through
    send_seq('{8'hC3}, 1'b0);
    write_mode(udfold_pkg::MODE_PASS);
    send_seq('{8'h78}, 1'b1);

    write_mode(udfold_pkg::MODE_TWO);
    send_seq('{8'hC3, 8'h9F, 8'hC3, 8'hA1, 8'hC5, 8'h90}, 1'b1);
    // two bytes held when the spare mode is written
    send_seq('{8'hC3, 8'hB6}, 1'b0);
    write_mode(MODE_SPARE);
    send_seq('{8'h79}, 1'b1);

    run_phase(udfold_pkg::MODE_ONE,  IDLE_NONE, 16);
    run_phase(udfold_pkg::MODE_TWO,  IDLE_SRC,  16);
    run_phase(udfold_pkg::MODE_ONE,  IDLE_SNK,  16);
    run_phase(udfold_pkg::MODE_TWO,  IDLE_BOTH, 16);
    run_phase(udfold_pkg::MODE_PASS, IDLE_BOTH, 16);
    run_phase(MODE_SPARE,            IDLE_NONE, 16);
    run_phase(udfold_pkg::MODE_TWO,  IDLE_SNK,  16);
    run_phase(udfold_pkg::MODE_ONE,  IDLE_SRC,  16);
    send_byte(8'h2E, 1'b1);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("fed %0d string bytes and checked %0d folded bytes", sb.n_in, sb.n_out);
    $display("modes 0 to 3, mode changes with bytes held, sender gaps and receiver stalls");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
